// ===== design/reciprocal_frequency_meter_defines.svh =====
// Assertion macros shared by the design files.
`ifndef RECIPROCAL_FREQUENCY_METER_DEFINES_SVH
`define RECIPROCAL_FREQUENCY_METER_DEFINES_SVH

// Same-cycle implication, checked outside of reset.
`define RFM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside of reset.
`define RFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/rfm_pkg.sv =====
`timescale 1ns / 1ps

package rfm_pkg;

    // Width of the capture timer and of the pulse counter.
    localparam int CNT_W      = 16;
    localparam int REF_W      = 21;
    localparam int FREQ_W     = 32;
    localparam logic [REF_W-1:0] REF_RESET = REF_W'(32768);

    // Product of delta and reference rate, then times ten (needs four more bits).
    localparam int MUL_W      = CNT_W + REF_W;
    localparam int PROD_W     = MUL_W + 4;
    localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

    localparam int IN_DATA_W  = ((2 * CNT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((FREQ_W + 2 * CNT_W + 7) / 8) * 8;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_REF_CLOCK = 1'b0;

    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] dividend;
        logic [CNT_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== design/rfm_apb_regs.sv =====
`timescale 1ns / 1ps

module rfm_apb_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rfm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rfm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rfm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready,
    output logic [rfm_pkg::REF_W-1:0]       o_ref_clock_hz
);
    import rfm_pkg::*;

    logic [REF_W-1:0] r_ref_clock_hz;
    logic             w_sel_ref;

    // The register index is the address bit above the byte offset.
    assign w_sel_ref = (paddr[APB_ADDR_W-1] == REG_REF_CLOCK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_clock_hz <= REF_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_ref) begin
            r_ref_clock_hz <= pwdata[REF_W-1:0];
        end
    end

    assign pready         = 1'b1;
    assign prdata         = w_sel_ref ? APB_DATA_W'(r_ref_clock_hz) : '0;
    assign o_ref_clock_hz = r_ref_clock_hz;

endmodule

// ===== design/rfm_div.sv =====
`timescale 1ns / 1ps
`include "reciprocal_frequency_meter_defines.svh"

module rfm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rfm_pkg::t_div_req i_req,
    output rfm_pkg::t_div_rsp o_rsp
);
    import rfm_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0]     r_div;
    logic [CNT_W-1:0]     r_rem;
    logic [PROD_W-1:0]    r_quo;

    logic [CNT_W:0]       w_trial;
    logic                 w_ge;
    logic [CNT_W:0]       w_diff;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    assign w_trial = {r_rem, r_quo[PROD_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_div  <= '0;
            r_rem  <= '0;
            r_quo  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_trial[CNT_W-1:0];
                r_quo <= {r_quo[PROD_W-2:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(PROD_W);
                r_div  <= i_req.divisor;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    `RFM_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_req.start && !r_busy, r_busy)
    `RFM_ASSERT_IMPL(a_rem_below_div, i_clk, i_rst_n, r_busy && (r_div != '0), r_rem < r_div)
    `RFM_ASSERT_NEXT(a_done_single, i_clk, i_rst_n, r_done, !r_done && !r_busy)

endmodule

// ===== design/reciprocal_frequency_meter.sv =====
`timescale 1ns / 1ps
// Channel    Direction  Handshake                      Contents
// s_axis     in         s_axis_tvalid/s_axis_tready    capture_time, pulse_count
// m_axis     out        m_axis_tvalid/m_axis_tready    freq, deltas; tuser divide_fault
// apb        in         psel/penable/pwrite, pready=1  ref_clock_hz at address 0
//
// A capture word goes through these steps from acceptance to a result word: the deltas are
// formed at acceptance, then the sequencer multiplies, scales by ten and loads the bit-serial
// restoring divider, which works through the 41-bit product one quotient bit at a time; the
// quotient is then saturated and the output register loaded, after which the sequencer
// returns to idle for the next word. A zero time delta skips the arithmetic and goes
// straight to the output register. Reset is synchronous and active low; it clears the
// stored capture and count and loads ref_clock_hz with 32768. s_axis_tready is high only
// between words; a held result word stalls the sequencer before the output register.
`include "reciprocal_frequency_meter_defines.svh"

module reciprocal_frequency_meter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] capture_time, [31:16] pulse_count
    input  logic [rfm_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [31:0] freq_tenths_hz, [47:32] pulse_delta, [63:48] time_delta
    output logic [rfm_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // [0] divide_fault
    output logic [0:0]                      m_axis_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [rfm_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [rfm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [rfm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import rfm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_DIV,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [CNT_W-1:0]    r_last_time;
    logic [CNT_W-1:0]    r_last_count;
    logic [CNT_W-1:0]    r_dt;
    logic [CNT_W-1:0]    r_dp;
    logic                r_fault;
    logic [PROD_W-1:0]   r_prod;
    logic [FREQ_W-1:0]   r_freq;
    logic                r_div_start;
    logic                r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                r_m_fault;

    logic [REF_W-1:0]    w_ref_clock_hz;
    logic [CNT_W-1:0]    w_now_time;
    logic [CNT_W-1:0]    w_now_count;
    logic [CNT_W-1:0]    w_dt;
    logic                w_in_take;
    logic                w_out_load;
    t_div_req            w_div_req;
    t_div_rsp            w_div_rsp;

    rfm_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_ref_clock_hz (w_ref_clock_hz)
    );

    assign w_div_req.start    = r_div_start;
    assign w_div_req.dividend = r_prod;
    assign w_div_req.divisor  = r_dt;

    rfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_now_time  = s_axis_tdata[CNT_W-1:0];
    assign w_now_count = s_axis_tdata[2*CNT_W-1:CNT_W];
    assign w_dt        = w_now_time - r_last_time;
    assign w_in_take   = s_axis_tvalid && s_axis_tready;
    assign w_out_load  = (r_state == S_OUT) && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_last_time  <= '0;
            r_last_count <= '0;
            r_dt         <= '0;
            r_dp         <= '0;
            r_fault      <= 1'b0;
            r_prod       <= '0;
            r_freq       <= '0;
            r_div_start  <= 1'b0;
            r_m_valid    <= 1'b0;
            r_m_data     <= '0;
            r_m_fault    <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (w_out_load) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_take) begin
                        r_last_time  <= w_now_time;
                        r_last_count <= w_now_count;
                        r_dt         <= w_dt;
                        r_dp         <= w_now_count - r_last_count;
                        r_fault      <= (w_dt == '0);
                        r_freq       <= '0;
                        r_state      <= (w_dt == '0) ? S_OUT : S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(MUL_W'(r_dp) * MUL_W'(w_ref_clock_hz));
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    // Times ten as eight plus two; the top four bits are free.
                    r_prod      <= (r_prod << 3) + (r_prod << 1);
                    r_div_start <= 1'b1;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_freq  <= (|w_div_rsp.quotient[PROD_W-1:FREQ_W]) ?
                                   '1 : w_div_rsp.quotient[FREQ_W-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (w_out_load) begin
                        r_m_data  <= OUT_DATA_W'({r_dt, r_dp, r_freq});
                        r_m_fault <= r_fault;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_fault;

endmodule

// ===== sim/rfm_checker.sv =====
`timescale 1ns / 1ps

module rfm_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    // [15:0] capture_time, [31:16] pulse_count
    input  logic [rfm_pkg::IN_DATA_W-1:0]  i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    // [31:0] freq_tenths_hz, [47:32] pulse_delta, [63:48] time_delta
    input  logic [rfm_pkg::OUT_DATA_W-1:0] i_out_data,
    // [0] divide_fault
    input  logic [0:0]                     i_out_user,
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic [rfm_pkg::APB_ADDR_W-1:0] i_paddr,
    input  logic [rfm_pkg::APB_DATA_W-1:0] i_pwdata,
    input  logic [rfm_pkg::APB_DATA_W-1:0] i_prdata,
    input  logic                           i_pready,
    output int                             o_fail_count,
    output int                             o_pending
);
    import rfm_pkg::*;

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [CNT_W-1:0]  pulse_delta;
        logic [CNT_W-1:0]  time_delta;
        logic              fault;
    } t_meter_reading;

    t_meter_reading   readings_due[$];
    logic [CNT_W-1:0] prev_capture;
    logic [CNT_W-1:0] prev_count;
    logic [REF_W-1:0] ref_rate;
    int               fail_total = 0;
    int               pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    function automatic t_meter_reading predict_reading(
        input logic [CNT_W-1:0] capture,
        input logic [CNT_W-1:0] count,
        input logic [CNT_W-1:0] last_capture,
        input logic [CNT_W-1:0] last_count,
        input logic [REF_W-1:0] rate
    );
        t_meter_reading r;
        logic [63:0]    product;
        logic [63:0]    quotient;
        r.time_delta  = capture - last_capture;
        r.pulse_delta = count - last_count;
        r.fault       = (r.time_delta == '0);
        r.freq        = '0;
        if (!r.fault) begin
            // The product needs at most 41 bits, so 64-bit math is exact.
            product  = 64'(r.pulse_delta) * 64'(rate) * 64'd10;
            quotient = product / 64'(r.time_delta);
            r.freq   = (quotient > 64'hFFFF_FFFF) ? '1 : quotient[FREQ_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        fail_total++;
    endtask

    always @(posedge i_clk) begin
        t_meter_reading want;
        if (!i_rst_n) begin
            prev_capture = '0;
            prev_count   = '0;
            ref_rate     = REF_RESET;
            readings_due.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (readings_due.size() == 0) begin
                    report_mismatch("result word with none expected", 64'(i_out_data), '0);
                end else begin
                    want = readings_due.pop_front();
                    if (i_out_data[FREQ_W-1:0] != want.freq)
                        report_mismatch("freq_tenths_hz", 64'(i_out_data[FREQ_W-1:0]),
                                        64'(want.freq));
                    if (i_out_data[FREQ_W +: CNT_W] != want.pulse_delta)
                        report_mismatch("pulse_delta", 64'(i_out_data[FREQ_W +: CNT_W]),
                                        64'(want.pulse_delta));
                    if (i_out_data[FREQ_W+CNT_W +: CNT_W] != want.time_delta)
                        report_mismatch("time_delta", 64'(i_out_data[FREQ_W+CNT_W +: CNT_W]),
                                        64'(want.time_delta));
                    if (i_out_user[0] !== want.fault)
                        report_mismatch("divide_fault", 64'(i_out_user[0]), 64'(want.fault));
                end
            end
            if (i_in_valid && i_in_ready) begin
                want = predict_reading(i_in_data[CNT_W-1:0], i_in_data[CNT_W +: CNT_W],
                                       prev_capture, prev_count, ref_rate);
                readings_due.push_back(want);
                prev_capture = i_in_data[CNT_W-1:0];
                prev_count   = i_in_data[CNT_W +: CNT_W];
            end
            // Only the reference-rate register is mapped; other addresses are ignored.
            if (i_psel && i_penable && i_pready && i_paddr[APB_ADDR_W-1:2] == REG_REF_CLOCK) begin
                if (i_pwrite)
                    ref_rate = i_pwdata[REF_W-1:0];
                else if (i_prdata !== APB_DATA_W'(ref_rate))
                    report_mismatch("ref_clock_hz readback", 64'(i_prdata), 64'(ref_rate));
            end
        end
        pending_total = readings_due.size();
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import rfm_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_REF_CLOCK = {REG_REF_CLOCK, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED  = {~REG_REF_CLOCK, 2'b00};
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 160;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [0:0]            m_axis_tuser;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int                    fail_count;
    int                    pending_count;
    logic                  quiet_tail = 1'b0;
    int                    rx_stall_left = 0;
    logic [CNT_W-1:0]      cur_time = '0;
    logic [CNT_W-1:0]      cur_count = '0;
    logic [31:0]           rate_plan [PHASES];

    reciprocal_frequency_meter u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    rfm_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_user   (m_axis_tuser),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The result side stalls in random bursts, except near the end of the run.
    always @(negedge i_clk) begin
        if (quiet_tail) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall_left > 0) begin
            rx_stall_left = rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_stall_left = $urandom_range(1, 11) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    task automatic apb_access(input logic is_write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_capture(input logic [CNT_W-1:0] capture, input logic [CNT_W-1:0] count);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge i_clk);
        end
        s_axis_tdata  = {count, capture};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        cur_time  = capture;
        cur_count = count;
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid = 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Mostly a steady sensor with the timer moving forward, plus repeated
    // capture times, tiny steps and fully random words.
    task automatic send_random_capture();
        logic [CNT_W-1:0] capture;
        logic [CNT_W-1:0] count;
        int               pick;
        pick    = $urandom_range(0, 9);
        capture = cur_time;
        count   = cur_count;
        if (pick < 6) begin
            capture = cur_time + CNT_W'($urandom_range(1, 65535));
            count   = cur_count + CNT_W'($urandom_range(0, 2000));
        end else if (pick == 6) begin
            count = cur_count + CNT_W'($urandom);
        end else if (pick == 7) begin
            capture = cur_time + CNT_W'($urandom_range(1, 8));
            count   = cur_count + CNT_W'($urandom_range(0, 8));
        end else begin
            capture = CNT_W'($urandom);
            count   = CNT_W'($urandom);
        end
        send_capture(capture, count);
    endtask

    initial begin
        rate_plan[0] = 32'd1;
        rate_plan[1] = 32'd1048576;
        rate_plan[2] = 32'd0;
        rate_plan[3] = 32'hFFFF_FFFF;
        rate_plan[4] = $urandom_range(2, 1048575);
        rate_plan[5] = 32'(REF_RESET);

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed words at the reset rate; the first one compares against zero state.
        apb_access(1'b0, ADDR_REF_CLOCK, '0);
        send_capture(16'h0000, 16'h0000);
        send_capture(16'h0001, 16'h0001);
        send_capture(16'h0001, 16'hFFFF);
        send_capture(16'hFFFF, 16'hFFFF);
        send_capture(16'h0000, 16'h0000);
        send_capture(16'h0001, 16'hFFFF);
        send_capture(16'h0000, 16'hFFFE);
        send_capture(16'h5555, 16'hAAAA);
        send_capture(16'hAAAA, 16'h5555);
        send_capture(16'hFFFF, 16'hFFFF);

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_results_drained();
            apb_access(1'b1, ADDR_REF_CLOCK, rate_plan[phase]);
            apb_access(1'b1, ADDR_UNMAPPED, $urandom);
            apb_access(1'b0, ADDR_REF_CLOCK, '0);
            // Largest pulse delta over one tick, then one pulse over the longest span.
            send_capture(cur_time + 16'h0001, cur_count + 16'hFFFF);
            send_capture(cur_time + 16'hFFFF, cur_count + 16'h0001);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (phase == 2 && i == ITEMS_PER_PHASE / 2)
                    wait_results_drained();
                if (phase == PHASES - 1 && i == ITEMS_PER_PHASE / 3)
                    quiet_tail = 1'b1;
                send_random_capture();
            end
        end

        wait_results_drained();
        repeat (60) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/rfm_pkg.sv
design/rfm_apb_regs.sv
design/rfm_div.sv
design/reciprocal_frequency_meter.sv
sim/rfm_checker.sv
sim/testbench.sv
